FILE: rtl/collatz_sieve_join_check_macros.svh
// Assertion macros used by the checker file.
`ifndef COLLATZ_SIEVE_JOIN_CHECK_MACROS_SVH
`define COLLATZ_SIEVE_JOIN_CHECK_MACROS_SVH

// Same-cycle implication under the asynchronous reset.
`define CSJC_IMPLY(name, ck, rn, a, c) \
	name: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("csjc: implication check failed");

// Next-cycle implication under the asynchronous reset.
`define CSJC_NEXT(name, ck, rn, a, c) \
	name: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("csjc: next-cycle check failed");

`endif

FILE: rtl/csjc_pkg.sv
package csjc_pkg;

	localparam int STEPS = 17;
	localparam int RES_W = 17;
	localparam int DIST_W = 40;
	localparam int KEPT_W = 18;
	// Each step grows a value by at most a factor of 1.5, about 0.585 bits.
	localparam int VAL_W = RES_W + (STEPS * 585 + 999) / 1000 + 1;
	localparam int CNT_W = $clog2(STEPS + 1);
	localparam logic [DIST_W-1:0] MAXD_RESET = DIST_W'(21845);

	typedef struct packed {
		logic is_tbl;
		logic [VAL_W-1:0] val;
		logic [CNT_W-1:0] odd_cnt;
		logic [RES_W-1:0] cand_m;
		logic hit;
	} pay_t;

	typedef struct packed {
		logic valid;
		pay_t pay;
	} tok_t;

endpackage

FILE: rtl/csjc_cell.sv
module csjc_cell (
	input logic clk,
	input logic arst_n,
	input csjc_pkg::tok_t din,
	output csjc_pkg::tok_t dout
);

	logic [csjc_pkg::VAL_W-1:0] half;
	logic [csjc_pkg::VAL_W-1:0] nval;
	logic [csjc_pkg::CNT_W-1:0] ncnt;
	logic match;
	logic vld_q;
	csjc_pkg::pay_t pay_q;
	logic [csjc_pkg::VAL_W-1:0] tv_q;
	logic [csjc_pkg::CNT_W-1:0] to_q;

	always_comb begin
		half = din.pay.val >> 1;
		if (din.pay.val[0]) begin
			nval = half + (half << 1) + csjc_pkg::VAL_W'(2);
			ncnt = din.pay.odd_cnt + csjc_pkg::CNT_W'(1);
		end else begin
			nval = half;
			ncnt = din.pay.odd_cnt;
			// A candidate whose halving lands on one is sent to zero instead.
			if (!din.pay.is_tbl && half == csjc_pkg::VAL_W'(1)) begin
				nval = '0;
			end
		end
		match = (nval == tv_q) && (ncnt == to_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid) begin
			pay_q.is_tbl <= din.pay.is_tbl;
			pay_q.val <= nval;
			pay_q.odd_cnt <= ncnt;
			pay_q.cand_m <= din.pay.cand_m;
			pay_q.hit <= din.pay.hit | (!din.pay.is_tbl & match);
			if (din.pay.is_tbl) begin
				tv_q <= nval;
				to_q <= ncnt;
			end
		end
	end

	assign dout.valid = vld_q;
	assign dout.pay = pay_q;

endmodule

FILE: rtl/collatz_sieve_join_check.sv
// Collatz sieve join check. Each residue first sends its own trajectory down a row of
// seventeen step cells, where each cell keeps its step of the table, and then issues the
// candidates residue-1, residue-2, ... into the same row at one candidate per cycle. The
// result is offered after the drain that follows the last candidate, and the next residue
// is taken only once the result has been accepted. The number of candidates issued is
// min(max_distance, residue - 2) when no candidate joins; when one does, it is the joining
// distance plus eighteen, or that limit if smaller, since the issue stops once the first
// join is seen at the end of the row. Residues 0, 1 and 2, and a max_distance of 0, issue
// no candidate. One item is worked on at a time; cfg_ready is always high and max_distance
// should be written only while no item is in progress.
module collatz_sieve_join_check (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [csjc_pkg::DIST_W-1:0] max_distance,
	input logic in_valid,
	output logic in_ready,
	input logic [csjc_pkg::RES_W-1:0] residue,
	output logic out_valid,
	input logic out_ready,
	output logic needs_testing,
	output logic [csjc_pkg::DIST_W-1:0] join_distance,
	output logic [csjc_pkg::KEPT_W-1:0] kept_total,
	output logic [csjc_pkg::DIST_W-1:0] largest_join
);

	localparam int DRAIN_LEN = csjc_pkg::STEPS + 2;
	localparam int DCNT_W = $clog2(DRAIN_LEN);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT = 4'b1000
	} state_t;

	state_t state_q;
	logic [csjc_pkg::DIST_W-1:0] maxd_q;
	logic [csjc_pkg::RES_W-1:0] b0_q;
	logic [csjc_pkg::RES_W-1:0] limit_q;
	logic [csjc_pkg::RES_W-1:0] m_q;
	logic found_q;
	logic [csjc_pkg::RES_W-1:0] fdist_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic issue_vld_q;
	csjc_pkg::pay_t issue_pay_q;
	logic needs_q;
	logic [csjc_pkg::DIST_W-1:0] jdist_q;
	logic [csjc_pkg::KEPT_W-1:0] kept_q;
	logic [csjc_pkg::DIST_W-1:0] maxj_q;

	csjc_pkg::tok_t chain [0:csjc_pkg::STEPS];
	csjc_pkg::tok_t tail;
	logic accept_in;
	logic cand_go;
	logic hit_now;
	logic found_fin;
	logic [csjc_pkg::RES_W-1:0] dist_fin;
	logic [csjc_pkg::RES_W-1:0] b0m2;
	logic [csjc_pkg::RES_W-1:0] limit_new;

	assign chain[0].valid = issue_vld_q;
	assign chain[0].pay = issue_pay_q;

	genvar k;
	generate
		for (k = 1; k <= csjc_pkg::STEPS; k++) begin : g_cell
			csjc_cell u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.din(chain[k-1]),
				.dout(chain[k])
			);
		end
	endgenerate

	assign tail = chain[csjc_pkg::STEPS];

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign accept_in = in_valid && in_ready;
	assign cand_go = (state_q == ST_RUN) && !found_q && (m_q <= limit_q);
	assign hit_now = tail.valid && !tail.pay.is_tbl && tail.pay.hit && !found_q
		&& (state_q == ST_RUN || state_q == ST_DRAIN);
	assign found_fin = found_q || hit_now;
	assign dist_fin = found_q ? fdist_q : tail.pay.cand_m;

	always_comb begin
		b0m2 = (residue >= csjc_pkg::RES_W'(3)) ? residue - csjc_pkg::RES_W'(2) : '0;
		if (maxd_q < csjc_pkg::DIST_W'(b0m2)) begin
			limit_new = maxd_q[csjc_pkg::RES_W-1:0];
		end else begin
			limit_new = b0m2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			maxd_q <= csjc_pkg::MAXD_RESET;
			found_q <= 1'b0;
			dcnt_q <= '0;
			issue_vld_q <= 1'b0;
			kept_q <= '0;
			maxj_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				maxd_q <= max_distance;
			end
			issue_vld_q <= accept_in || cand_go;
			if (hit_now) begin
				found_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						found_q <= 1'b0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!cand_go) begin
						dcnt_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (dcnt_q == DCNT_W'(DRAIN_LEN - 1)) begin
						if (!found_fin) begin
							kept_q <= kept_q + csjc_pkg::KEPT_W'(1);
						end else if (csjc_pkg::DIST_W'(dist_fin) > maxj_q) begin
							maxj_q <= csjc_pkg::DIST_W'(dist_fin);
						end
						state_q <= ST_OUT;
					end else begin
						dcnt_q <= dcnt_q + DCNT_W'(1);
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			b0_q <= residue;
			limit_q <= limit_new;
			m_q <= csjc_pkg::RES_W'(1);
			issue_pay_q.is_tbl <= 1'b1;
			issue_pay_q.val <= csjc_pkg::VAL_W'(residue);
			issue_pay_q.odd_cnt <= '0;
			issue_pay_q.cand_m <= '0;
			issue_pay_q.hit <= 1'b0;
		end else if (cand_go) begin
			m_q <= m_q + csjc_pkg::RES_W'(1);
			issue_pay_q.is_tbl <= 1'b0;
			issue_pay_q.val <= csjc_pkg::VAL_W'(b0_q - m_q);
			issue_pay_q.odd_cnt <= '0;
			issue_pay_q.cand_m <= m_q;
			issue_pay_q.hit <= 1'b0;
		end
		if (hit_now) begin
			fdist_q <= tail.pay.cand_m;
		end
		if (state_q == ST_DRAIN && dcnt_q == DCNT_W'(DRAIN_LEN - 1)) begin
			needs_q <= !found_fin;
			jdist_q <= found_fin ? csjc_pkg::DIST_W'(dist_fin) : '0;
		end
	end

	assign out_valid = (state_q == ST_OUT);
	assign needs_testing = needs_q;
	assign join_distance = jdist_q;
	assign kept_total = kept_q;
	assign largest_join = maxj_q;

endmodule

FILE: rtl/csjc_checker.sv
`include "collatz_sieve_join_check_macros.svh"

module csjc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic needs_testing,
	input logic [csjc_pkg::DIST_W-1:0] join_distance,
	input logic [csjc_pkg::KEPT_W-1:0] kept_total,
	input logic [csjc_pkg::DIST_W-1:0] largest_join
);

	`CSJC_IMPLY(a_kept_no_dist, clk, arst_n, out_valid && needs_testing, join_distance == '0)
	`CSJC_IMPLY(a_join_bounded, clk, arst_n, out_valid && !needs_testing, (join_distance != '0) && (largest_join >= join_distance))
	`CSJC_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready && !out_valid)
	`CSJC_NEXT(a_single_result, clk, arst_n, out_valid && out_ready, !out_valid)
	`CSJC_NEXT(a_result_held, clk, arst_n, out_valid && !out_ready, out_valid && $stable(join_distance) && $stable(kept_total))

endmodule

bind collatz_sieve_join_check csjc_checker u_csjc_checker (.*);

FILE: dv/collatz_sieve_join_check_test.sv
module collatz_sieve_join_check_test;
	import csjc_pkg::*;

	localparam int GAP_MAX = 11;
	localparam int SETTLE_CYCLES = 40;
	localparam int RESIDUE_TOP = 2 ** RES_W - 1;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;

	typedef struct packed {
		logic needs_testing;
		logic [DIST_W-1:0] join_distance;
		logic [KEPT_W-1:0] kept_total;
		logic [DIST_W-1:0] largest_join;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [DIST_W-1:0] max_distance;
	logic in_valid;
	logic in_ready;
	logic [RES_W-1:0] residue;
	logic out_valid;
	logic out_ready;
	logic needs_testing;
	logic [DIST_W-1:0] join_distance;
	logic [KEPT_W-1:0] kept_total;
	logic [DIST_W-1:0] largest_join;

	// Shadow copy of the residue's trajectory and of the running totals.
	logic [63:0] path_value [0:STEPS];
	logic [5:0] path_odd [0:STEPS];
	logic [DIST_W-1:0] distance_cap;
	logic [KEPT_W-1:0] kept_so_far;
	logic [DIST_W-1:0] longest_join;

	verdict_t pending_verdicts[$];
	int fault_count = 0;
	longint cycle_count = 0;
	bit sender_gaps = 1'b1;
	bit receiver_stalls = 1'b1;

	collatz_sieve_join_check dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_distance(max_distance),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.residue(residue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.needs_testing(needs_testing),
		.join_distance(join_distance),
		.kept_total(kept_total),
		.largest_join(largest_join)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit joins_path(logic [63:0] start);
		logic [63:0] x;
		logic [5:0] odd;
		x = start;
		odd = '0;
		for (int j = 1; j <= STEPS; j++) begin
			if (x[0]) begin
				x = 64'd3 * (x >> 1) + 64'd2;
				odd = odd + 6'd1;
			end else begin
				x = x >> 1;
				if (x == 64'd1)
					x = '0;
			end
			if (x == path_value[j] && odd == path_odd[j])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic verdict_t judge_residue(logic [RES_W-1:0] r);
		verdict_t v;
		logic [63:0] span;
		logic [63:0] m;
		logic [63:0] found;
		path_value[0] = 64'(r);
		path_odd[0] = '0;
		for (int i = 1; i <= STEPS; i++) begin
			if (path_value[i-1][0]) begin
				path_value[i] = 64'd3 * (path_value[i-1] >> 1) + 64'd2;
				path_odd[i] = path_odd[i-1] + 6'd1;
			end else begin
				path_value[i] = path_value[i-1] >> 1;
				path_odd[i] = path_odd[i-1];
			end
		end
		span = (r >= 3) ? 64'(r) - 64'd2 : 64'd0;
		if (64'(distance_cap) < span)
			span = 64'(distance_cap);
		found = '0;
		m = 64'd1;
		while (found == 0 && m <= span) begin
			if (joins_path(64'(r) - m))
				found = m;
			m = m + 64'd1;
		end
		if (found == 0)
			kept_so_far = kept_so_far + 1'b1;
		else if (found[DIST_W-1:0] > longest_join)
			longest_join = found[DIST_W-1:0];
		v.needs_testing = (found == 0);
		v.join_distance = found[DIST_W-1:0];
		v.kept_total = kept_so_far;
		v.largest_join = longest_join;
		return v;
	endfunction

	task automatic offer_residue(input logic [RES_W-1:0] r);
		int gap;
		gap = sender_gaps ? $urandom_range(0, GAP_MAX) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		residue <= r;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_verdicts.push_back(judge_residue(r));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_distance(input logic [DIST_W-1:0] value);
		cfg_valid <= 1'b1;
		max_distance <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		distance_cap = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random_phase(input logic [DIST_W-1:0] cap, input int count,
			input int residue_top, input bit gaps, input bit stalls);
		sender_gaps = gaps;
		receiver_stalls = stalls;
		write_max_distance(cap);
		repeat (count) offer_residue(RES_W'($urandom_range(0, residue_top)));
		settle();
	endtask

	task automatic test_default_distance();
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		offer_residue(RES_W'(0));
		offer_residue(RES_W'(1));
		offer_residue(RES_W'(2));
		offer_residue(RES_W'(3));
		offer_residue(RES_W'(4));
		offer_residue(RES_W'(5));
		offer_residue(RES_W'(27));
		offer_residue(RES_W'(RESIDUE_TOP));
		settle();
	endtask

	task automatic test_zero_distance();
		write_max_distance('0);
		offer_residue(RES_W'(RESIDUE_TOP));
		offer_residue(RES_W'(3));
		offer_residue(RES_W'(65536));
		settle();
	endtask

	task automatic test_unit_distance();
		write_max_distance(DIST_W'(1));
		offer_residue(RES_W'(4));
		offer_residue(RES_W'(5));
		offer_residue(RES_W'(6));
		offer_residue(RES_W'(7));
		settle();
	endtask

	task automatic test_full_distance();
		write_max_distance(DIST_ALL_ONES);
		offer_residue(RES_W'(27));
		offer_residue(RES_W'(255));
		offer_residue(RES_W'(RESIDUE_TOP));
		settle();
	endtask

	task automatic test_short_distances();
		run_random_phase(DIST_W'($urandom_range(2, 300)), 15, RESIDUE_TOP, 1'b1, 1'b1);
		run_random_phase(DIST_W'($urandom_range(2, 300)), 10, RESIDUE_TOP, 1'b0, 1'b0);
	endtask

	task automatic test_wide_distance();
		run_random_phase(DIST_W'({$urandom, $urandom}), 20, 1500, 1'b0, 1'b1);
	endtask

	task automatic test_moderate_distances();
		run_random_phase(DIST_W'($urandom_range(300, 3000)), 25, RESIDUE_TOP, 1'b1, 1'b0);
	endtask

	task automatic test_mixed_residues();
		run_random_phase(DIST_W'($urandom_range(0, 40)), 10, 8, 1'b1, 1'b1);
		run_random_phase(DIST_W'($urandom_range(0, 40)), 20, RESIDUE_TOP, 1'b1, 1'b1);
	endtask

	initial begin
		int gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = receiver_stalls ? $urandom_range(0, GAP_MAX) : 0;
			if (gap != 0) begin
				out_ready <= 1'b0;
				do @(posedge clk); while (out_valid !== 1'b1);
				repeat (gap - 1) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_ready === 1'b1));
		end
	end

	always @(posedge clk) begin : check_results
		verdict_t want;
		verdict_t got;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			got = {needs_testing, join_distance, kept_total, largest_join};
			if (pending_verdicts.size() == 0) begin
				if (fault_count < 10)
					$display("Unexpected result: keep=%0b join=%0d kept=%0d largest=%0d",
						got.needs_testing, got.join_distance, got.kept_total,
						got.largest_join);
				fault_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (got !== want) begin
					if (fault_count < 10)
						$display({"Mismatch: expected keep=%0b join=%0d kept=%0d largest=%0d,",
							" got keep=%0b join=%0d kept=%0d largest=%0d"},
							want.needs_testing, want.join_distance, want.kept_total,
							want.largest_join, got.needs_testing, got.join_distance,
							got.kept_total, got.largest_join);
					fault_count++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		max_distance = '0;
		in_valid = 1'b0;
		residue = '0;
		distance_cap = MAXD_RESET;
		kept_so_far = '0;
		longest_join = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_distance();
		test_zero_distance();
		test_unit_distance();
		test_full_distance();
		test_short_distances();
		test_wide_distance();
		test_moderate_distances();
		test_mixed_residues();
		if (fault_count == 0 && pending_verdicts.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/csjc_pkg.sv
rtl/csjc_cell.sv
rtl/collatz_sieve_join_check.sv
rtl/csjc_checker.sv
dv/collatz_sieve_join_check_test.sv
